>>> hdl/min_max_priority_queue_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the min/max priority queue
// Concurrent assertion helpers; they compile to nothing when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef MIN_MAX_PRIORITY_QUEUE_MACROS_SVH
`define MIN_MAX_PRIORITY_QUEUE_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define MMPQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("mmpq: assertion failed");
// next-cycle implication
`define MMPQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("mmpq: assertion failed");
`else
`define MMPQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define MMPQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> hdl/mmpq_pkg.sv
// ----------------------------------------------------------------------------
// mmpq_pkg
// Types, codes and constants shared by the min/max priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package mmpq_pkg;

	localparam int unsigned CAPACITY_DEF = 64;
	localparam int unsigned VALUE_W      = 31;
	localparam int unsigned COUNT_W      = 7;
	localparam int unsigned STATUS_W     = 2;

	typedef logic signed [VALUE_W-1:0] value_t;
	typedef logic [COUNT_W-1:0]        count_t;
	typedef logic [STATUS_W-1:0]       status_t;

	// value limits, also the empty-queue readings
	localparam value_t VAL_TOP    = 31'sd1000000000;
	localparam value_t VAL_BOTTOM = -31'sd1000000000;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	localparam status_t STAT_OK    = 2'd0;
	localparam status_t STAT_FULL  = 2'd1;
	localparam status_t STAT_EMPTY = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SCAN,
		ST_FIX,
		ST_DONE
	} mmpq_state_t;

	function automatic value_t clamp_value(value_t v);
		value_t r;
		r = v;
		if (v > VAL_TOP) begin
			r = VAL_TOP;
		end else if (v < VAL_BOTTOM) begin
			r = VAL_BOTTOM;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

>>> hdl/mmpq_ifs.sv
// ----------------------------------------------------------------------------
// mmpq channel interfaces
// Command and response channels with a valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface mmpq_cmd_if;
	import mmpq_pkg::*;

	logic   valid;
	logic   ready;
	logic   opcode;
	value_t value;

	modport source (output valid, output opcode, output value, input ready);
	modport sink   (input valid, input opcode, input value, output ready);
endinterface

interface mmpq_rsp_if;
	import mmpq_pkg::*;

	logic    valid;
	logic    ready;
	count_t  count;
	value_t  largest;
	value_t  smallest;
	status_t status;

	modport source (output valid, output count, output largest, output smallest,
		output status, input ready);
	modport sink   (input valid, input count, input largest, input smallest,
		input status, output ready);
endinterface

`default_nettype wire

>>> hdl/mmpq_ram.sv
// ----------------------------------------------------------------------------
// mmpq_ram
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mmpq_ram #(
	parameter int unsigned DEPTH = mmpq_pkg::CAPACITY_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  mmpq_pkg::value_t         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output mmpq_pkg::value_t         rdata
);
	import mmpq_pkg::*;

	value_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

>>> hdl/min_max_priority_queue.sv
// ----------------------------------------------------------------------------
// min_max_priority_queue
// Bounded max-priority queue over an unsorted entry RAM; reports count,
// largest and smallest after every command.
// ----------------------------------------------------------------------------
//
//  channel | dir | payload                               | transfer when
//  --------+-----+---------------------------------------+-------------------
//  cmd     | in  | opcode, value                         | valid && ready
//  rsp     | out | count, largest, smallest, status      | valid && ready
//
//  Insert: from cmd transfer, states EXEC and DONE lead to the result register;
//  largest/smallest are updated against the new value.
//  Remove: states EXEC, SCAN, FIX and DONE, or EXEC and DONE on an empty
//  queue; the single read port of the entry RAM is swept once, one entry per
//  cycle, to find the largest copy, the runner-up, the smallest and the last
//  entry. The block returns to idle before the next cmd transfer.
//  Reset clears state, count, read index, valid flags and largest/smallest
//  registers; the RAM needs no clearing pass since only entries below the
//  count are read. A response waits in the output register while rsp stalls;
//  cmd is taken again as soon as the block is back in idle.
//
`default_nettype none
`include "min_max_priority_queue_macros.svh"

module min_max_priority_queue #(
	parameter int unsigned CAPACITY = mmpq_pkg::CAPACITY_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	mmpq_cmd_if.sink   cmd,
	mmpq_rsp_if.source rsp
);
	import mmpq_pkg::*;

	localparam int unsigned AW = $clog2(CAPACITY);
	localparam int unsigned CW = $clog2(CAPACITY + 1);
	localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);
	localparam logic [CW-1:0] ONE_CNT = CW'(1);

	// control
	mmpq_state_t   state_q, state_d;
	logic [CW-1:0] count_q;
	logic [CW-1:0] rd_idx_q;
	logic          rd_vld_s1;
	logic [AW-1:0] rd_at_s1;
	logic          out_vld_q;

	// command and running extremes
	logic    op_q;
	value_t  val_q;
	value_t  hi_q, lo_q;
	status_t stat_q;

	// sweep accumulators
	value_t        best_q, second_q, min_q, last_q;
	logic [AW-1:0] best_at_q;
	logic [AW-1:0] last_at;

	// RAM ports
	logic          ram_we, ram_re;
	logic [AW-1:0] ram_waddr;
	value_t        ram_wdata;
	value_t        rd_data_s1;

	// result register
	count_t  out_cnt_q;
	value_t  out_hi_q, out_lo_q;
	status_t out_stat_q;

	logic cmd_xfer, out_load;

	assign cmd_xfer = cmd.valid && cmd.ready;
	assign out_load = (state_q == ST_DONE) && (!out_vld_q || rsp.ready);
	assign last_at  = AW'(count_q - ONE_CNT);

	mmpq_ram #(.DEPTH(CAPACITY)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (rd_idx_q[AW-1:0]),
		.rdata (rd_data_s1)
	);

	// next state and RAM control
	always_comb begin
		state_d   = state_q;
		cmd.ready = (state_q == ST_IDLE);
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		ram_waddr = count_q[AW-1:0];
		ram_wdata = val_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd.valid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (op_q == OP_INSERT) begin
					// append at the tail unless full
					ram_we  = (count_q != CAP_CNT);
					state_d = ST_DONE;
				end else if (count_q == '0) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				ram_re = (rd_idx_q < count_q);
				if (!ram_re && !rd_vld_s1) begin
					state_d = ST_FIX;
				end
			end
			ST_FIX: begin
				// last entry fills the slot of the removed largest copy
				ram_we    = 1'b1;
				ram_waddr = best_at_q;
				ram_wdata = last_q;
				state_d   = ST_DONE;
			end
			ST_DONE: begin
				if (!out_vld_q || rsp.ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// count, extremes, sweep control, result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			hi_q      <= VAL_BOTTOM;
			lo_q      <= VAL_TOP;
			rd_idx_q  <= '0;
			rd_vld_s1 <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			rd_vld_s1 <= ram_re;
			if (ram_re) begin
				rd_idx_q <= rd_idx_q + ONE_CNT;
			end
			if (state_q == ST_EXEC) begin
				rd_idx_q <= '0;
				if (op_q == OP_INSERT && count_q != CAP_CNT) begin
					count_q <= count_q + ONE_CNT;
					if (val_q > hi_q) begin
						hi_q <= val_q;
					end
					if (val_q < lo_q) begin
						lo_q <= val_q;
					end
				end
			end
			if (state_q == ST_FIX) begin
				count_q <= count_q - ONE_CNT;
				hi_q    <= second_q;
				lo_q    <= (count_q == ONE_CNT) ? VAL_TOP : min_q;
			end
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// command capture, status, sweep datapath, result register
	always_ff @(posedge clk) begin
		if (cmd_xfer) begin
			op_q  <= cmd.opcode;
			val_q <= clamp_value(cmd.value);
		end
		rd_at_s1 <= rd_idx_q[AW-1:0];
		if (state_q == ST_EXEC) begin
			best_q   <= VAL_BOTTOM;
			second_q <= VAL_BOTTOM;
			min_q    <= VAL_TOP;
			if (op_q == OP_INSERT) begin
				stat_q <= (count_q == CAP_CNT) ? STAT_FULL : STAT_OK;
			end else begin
				stat_q <= (count_q == '0) ? STAT_EMPTY : STAT_OK;
			end
		end
		if (state_q == ST_SCAN && rd_vld_s1) begin
			// keep the top two (duplicates count twice) and the minimum
			if (rd_data_s1 >= best_q) begin
				best_q    <= rd_data_s1;
				best_at_q <= rd_at_s1;
				second_q  <= best_q;
			end else if (rd_data_s1 > second_q) begin
				second_q <= rd_data_s1;
			end
			if (rd_data_s1 < min_q) begin
				min_q <= rd_data_s1;
			end
			if (rd_at_s1 == last_at) begin
				last_q <= rd_data_s1;
			end
		end
		if (out_load) begin
			out_cnt_q  <= COUNT_W'(count_q);
			out_hi_q   <= hi_q;
			out_lo_q   <= lo_q;
			out_stat_q <= stat_q;
		end
	end

	assign rsp.valid    = out_vld_q;
	assign rsp.count    = out_cnt_q;
	assign rsp.largest  = out_hi_q;
	assign rsp.smallest = out_lo_q;
	assign rsp.status   = out_stat_q;

	// checks
	`MMPQ_ASSERT_IMP(a_count_bound, clk, arst_n, 1'b1, count_q <= CAP_CNT)
	`MMPQ_ASSERT_NXT(a_xfer_starts, clk, arst_n, cmd_xfer, state_q == ST_EXEC)
	`MMPQ_ASSERT_IMP(a_hi_ge_lo, clk, arst_n, state_q == ST_IDLE && count_q != '0, hi_q >= lo_q)
	`MMPQ_ASSERT_IMP(a_full_count, clk, arst_n, rsp.valid && rsp.status == STAT_FULL, rsp.count == COUNT_W'(CAP_CNT))

endmodule

`default_nettype wire
